[design/gn_pkg.sv]
package gn_pkg;

  localparam int TABLE_SIZE   = 256;
  localparam int TBL_W        = $clog2(TABLE_SIZE);
  localparam int FRAC_BITS    = 16;
  localparam int COORD_OFFSET = 4096;
  localparam int COORD_W      = 32;
  localparam int GRAD_W       = 16;
  localparam int NOISE_W      = 16;
  localparam int REQ_W        = 3;
  localparam int TDATA_W      = 112;

  // fraction and s-curve widths
  localparam int RW  = FRAC_BITS + 1;        // signed r0 / r1
  localparam int PW  = RW + GRAD_W;          // one gradient product
  localparam int SUMW = PW + 1;              // dot product before shift
  localparam int DW  = SUMW - FRAC_BITS;     // dot product, Q.14
  localparam int MXW = DW + 1 + FRAC_BITS + 2;
  localparam int AW  = DW + 3;               // first lerp result
  localparam int MYW = AW + 1 + FRAC_BITS + 2;
  localparam int OW  = AW + 3;               // final lerp before saturation

  typedef enum logic [REQ_W-1:0] {
    REQ_PERM  = 3'd0,
    REQ_GRAD1 = 3'd1,
    REQ_GRAD2 = 3'd2,
    REQ_EVAL1 = 3'd3,
    REQ_EVAL2 = 3'd4
  } req_e;

endpackage

[design/gradient_noise_1d_2d.sv]
// lattice gradient noise, one or two dimensions
// s_axis: input words, tuser carries the request kind (load perm, load 1D gradient,
//   load 2D gradient, evaluate 1D, evaluate 2D); tdata carries index, values, coords.
// m_axis: one 16-bit Q2.14 noise word for each evaluate word; loads give no word.
// throughput: one word per cycle while m_axis is not stalled, loads and evaluates mixed freely.
// a result reaches m_axis through the eleven-register pipeline (split, three
//   table reads, products, dot sums, two lerp multiply/add pairs,
//   saturation).
// each table is read and written at the same pipeline stage, so a load takes
//   effect exactly for the evaluates accepted after it.
// reset clears all valid bits; table contents are undefined until loaded.
// a stalled receiver freezes the whole pipeline; s_axis_tready_o drops only
//   while a result waits and m_axis_tready_i is low.
module gradient_noise_1d_2d (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // table_index, perm_value, grad_x, grad_y, coord_x, coord_y
  input  logic [gn_pkg::TDATA_W-1:0]   s_axis_tdata_i,
  // req_type
  input  logic [gn_pkg::REQ_W-1:0]     s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // noise_value
  output logic [gn_pkg::NOISE_W-1:0]   m_axis_tdata_o
);
  import gn_pkg::*;

  localparam logic [COORD_W:0] OFFSET = (COORD_W+1)'(COORD_OFFSET) << FRAC_BITS;

  logic en;
  logic out_vq;
  logic [NOISE_W-1:0] out_q;

  assign en = !out_vq || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vq;
  assign m_axis_tdata_o  = out_q;

  // memories, one copy per pair of read ports
  logic [7:0]          perm_a [TABLE_SIZE];
  logic [7:0]          perm_b [TABLE_SIZE];
  logic [7:0]          perm_c [TABLE_SIZE];
  logic [GRAD_W-1:0]   grad1  [TABLE_SIZE];
  logic [2*GRAD_W-1:0] grad2_d [TABLE_SIZE];
  logic [2*GRAD_W-1:0] grad2_e [TABLE_SIZE];

  // stage valids and kinds
  logic [9:0]       v_q;
  logic [REQ_W-1:0] k0_q, k1_q, k2_q, k3_q, k4_q, k5_q, k6_q, k7_q, k8_q, k9_q;

  // stage 0: input
  logic [7:0]               idx0_q, pv0_q;
  logic [GRAD_W-1:0]        gx0_q, gy0_q;
  logic [COORD_W-1:0]       cx0_q, cy0_q;
  // stage 1: split
  logic [TBL_W-1:0]         idx1_q, bx1_q, by1_q;
  logic [7:0]               pv1_q;
  logic [GRAD_W-1:0]        gx1_q, gy1_q;
  logic [FRAC_BITS-1:0]     rx1_q, ry1_q;
  // stage 2: perm A data, squares
  logic [TBL_W-1:0]         idx2_q, by2_q, i2_q, j2_q;
  logic [7:0]               pv2_q;
  logic [GRAD_W-1:0]        gx2_q, gy2_q;
  logic [FRAC_BITS-1:0]     rx2_q, ry2_q, r2x2_q, r2y2_q;
  // stage 3: corner hashes, s-curves
  logic [TBL_W-1:0]         idx3_q, i3_q, j3_q;
  logic [TBL_W-1:0]         h00_q, h10_q, h01_q, h11_q;
  logic [GRAD_W-1:0]        gx3_q, gy3_q;
  logic [FRAC_BITS-1:0]     rx3_q, ry3_q;
  logic [FRAC_BITS:0]       sx3_q, sy3_q;
  // stage 4: gradients
  logic [GRAD_W-1:0]        g1a_q, g1b_q;
  logic [2*GRAD_W-1:0]      g00_q, g10_q, g01_q, g11_q;
  logic [FRAC_BITS-1:0]     rx4_q, ry4_q;
  logic [FRAC_BITS:0]       sx4_q, sy4_q;
  // stage 5: products
  logic signed [PW-1:0]     p00x_q, p00y_q, p10x_q, p10y_q, p01x_q, p01y_q, p11x_q, p11y_q;
  logic [FRAC_BITS:0]       sx5_q, sy5_q;
  // stage 6: dots
  logic signed [DW-1:0]     d00_q, d10_q, d01_q, d11_q;
  logic [FRAC_BITS:0]       sx6_q, sy6_q;
  // stage 7: x lerp products
  logic signed [MXW-1:0]    mxa_q, mxb_q;
  logic signed [DW-1:0]     d00_7_q, d01_7_q;
  logic [FRAC_BITS:0]       sy7_q;
  // stage 8: x lerps
  logic signed [AW-1:0]     a8_q, b8_q;
  logic [FRAC_BITS:0]       sy8_q;
  // stage 9: y lerp product
  logic signed [MYW-1:0]    my9_q;
  logic signed [AW-1:0]     a9_q;

  // stage 0 -> 1 split
  logic [COORD_W:0] tx_d, ty_d;
  assign tx_d = {cx0_q[COORD_W-1], cx0_q} + OFFSET;
  assign ty_d = {cy0_q[COORD_W-1], cy0_q} + OFFSET;

  // stage 2 hash addresses
  logic [TBL_W-1:0] by2p_d;
  assign by2p_d = by2_q + TBL_W'(1);

  // stage 2 s-curve
  logic [FRAC_BITS+1:0]   kx_d, ky_d;
  logic [2*FRAC_BITS+1:0] sxp_d, syp_d;
  assign kx_d  = (FRAC_BITS+2)'(3) << FRAC_BITS;
  assign ky_d  = (FRAC_BITS+2)'(3) << FRAC_BITS;
  assign sxp_d = r2x2_q * (kx_d - {1'b0, rx2_q, 1'b0});
  assign syp_d = r2y2_q * (ky_d - {1'b0, ry2_q, 1'b0});

  // stage 4 operands; 1D reuses the first two corners with y zeroed
  logic signed [RW-1:0]     rx0s, rx1s, ry0s, ry1s;
  logic signed [GRAD_W-1:0] g00x, g00y, g10x, g10y;
  logic                     is1d4;
  assign rx0s  = $signed({1'b0, rx4_q});
  assign rx1s  = $signed({1'b1, rx4_q});
  assign ry0s  = $signed({1'b0, ry4_q});
  assign ry1s  = $signed({1'b1, ry4_q});
  assign is1d4 = (k4_q == REQ_EVAL1);
  assign g00x  = is1d4 ? $signed(g1a_q) : $signed(g00_q[GRAD_W-1:0]);
  assign g00y  = is1d4 ? '0 : $signed(g00_q[2*GRAD_W-1:GRAD_W]);
  assign g10x  = is1d4 ? $signed(g1b_q) : $signed(g10_q[GRAD_W-1:0]);
  assign g10y  = is1d4 ? '0 : $signed(g10_q[2*GRAD_W-1:GRAD_W]);

  // stage 5 dot sums
  logic signed [SUMW-1:0] s00, s10, s01, s11;
  assign s00 = SUMW'(p00x_q) + SUMW'(p00y_q);
  assign s10 = SUMW'(p10x_q) + SUMW'(p10y_q);
  assign s01 = SUMW'(p01x_q) + SUMW'(p01y_q);
  assign s11 = SUMW'(p11x_q) + SUMW'(p11y_q);

  // stage 6 lerp differences
  logic signed [DW:0] dfa, dfb;
  assign dfa = (DW+1)'(d10_q) - (DW+1)'(d00_q);
  assign dfb = (DW+1)'(d11_q) - (DW+1)'(d01_q);

  // stage 8 and 9
  logic signed [AW:0]   dfy;
  logic signed [OW-1:0] res;
  logic [NOISE_W-1:0]   sat;
  assign dfy = (AW+1)'(b8_q) - (AW+1)'(a8_q);
  assign res = (k9_q == REQ_EVAL2) ? OW'(a9_q) + OW'(my9_q[MYW-1:FRAC_BITS]) : OW'(a9_q);
  always_comb begin
    if (res > OW'(32767)) begin
      sat = 16'h7fff;
    end else if (res < -OW'(32768)) begin
      sat = 16'h8000;
    end else begin
      sat = res[NOISE_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      out_vq <= 1'b0;
    end else if (en) begin
      v_q    <= {v_q[8:0], s_axis_tvalid_i};
      out_vq <= v_q[9] && (k9_q == REQ_EVAL1 || k9_q == REQ_EVAL2);
    end
  end

  // datapath and memories
  always_ff @(posedge clk_i) begin
    if (en) begin
      k0_q   <= s_axis_tuser_i;
      idx0_q <= s_axis_tdata_i[7:0];
      pv0_q  <= s_axis_tdata_i[15:8];
      gx0_q  <= s_axis_tdata_i[31:16];
      gy0_q  <= s_axis_tdata_i[47:32];
      cx0_q  <= s_axis_tdata_i[79:48];
      cy0_q  <= s_axis_tdata_i[111:80];

      k1_q   <= k0_q;
      idx1_q <= idx0_q[TBL_W-1:0];
      pv1_q  <= pv0_q;
      gx1_q  <= gx0_q;
      gy1_q  <= gy0_q;
      bx1_q  <= tx_d[FRAC_BITS +: TBL_W];
      by1_q  <= ty_d[FRAC_BITS +: TBL_W];
      rx1_q  <= tx_d[FRAC_BITS-1:0];
      ry1_q  <= ty_d[FRAC_BITS-1:0];

      if (v_q[1] && k1_q == REQ_PERM) begin
        perm_a[idx1_q] <= pv1_q;
      end
      i2_q   <= perm_a[bx1_q][TBL_W-1:0];
      j2_q   <= perm_a[bx1_q + TBL_W'(1)][TBL_W-1:0];
      k2_q   <= k1_q;
      idx2_q <= idx1_q;
      pv2_q  <= pv1_q;
      gx2_q  <= gx1_q;
      gy2_q  <= gy1_q;
      by2_q  <= by1_q;
      rx2_q  <= rx1_q;
      ry2_q  <= ry1_q;
      r2x2_q <= FRAC_BITS'((2*FRAC_BITS)'(rx1_q) * (2*FRAC_BITS)'(rx1_q) >> FRAC_BITS);
      r2y2_q <= FRAC_BITS'((2*FRAC_BITS)'(ry1_q) * (2*FRAC_BITS)'(ry1_q) >> FRAC_BITS);

      if (v_q[2] && k2_q == REQ_PERM) begin
        perm_b[idx2_q] <= pv2_q;
        perm_c[idx2_q] <= pv2_q;
      end
      h00_q  <= perm_b[i2_q + by2_q][TBL_W-1:0];
      h10_q  <= perm_b[j2_q + by2_q][TBL_W-1:0];
      h01_q  <= perm_c[i2_q + by2p_d][TBL_W-1:0];
      h11_q  <= perm_c[j2_q + by2p_d][TBL_W-1:0];
      k3_q   <= k2_q;
      idx3_q <= idx2_q;
      gx3_q  <= gx2_q;
      gy3_q  <= gy2_q;
      i3_q   <= i2_q;
      j3_q   <= j2_q;
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;
      sx3_q  <= sxp_d[2*FRAC_BITS:FRAC_BITS];
      sy3_q  <= syp_d[2*FRAC_BITS:FRAC_BITS];

      if (v_q[3] && k3_q == REQ_GRAD1) begin
        grad1[idx3_q] <= gx3_q;
      end
      if (v_q[3] && k3_q == REQ_GRAD2) begin
        grad2_d[idx3_q] <= {gy3_q, gx3_q};
        grad2_e[idx3_q] <= {gy3_q, gx3_q};
      end
      g1a_q <= grad1[i3_q];
      g1b_q <= grad1[j3_q];
      g00_q <= grad2_d[h00_q];
      g10_q <= grad2_d[h10_q];
      g01_q <= grad2_e[h01_q];
      g11_q <= grad2_e[h11_q];
      k4_q  <= k3_q;
      rx4_q <= rx3_q;
      ry4_q <= ry3_q;
      sx4_q <= sx3_q;
      sy4_q <= sy3_q;

      p00x_q <= PW'(rx0s * g00x);
      p00y_q <= PW'(ry0s * g00y);
      p10x_q <= PW'(rx1s * g10x);
      p10y_q <= PW'(ry0s * g10y);
      p01x_q <= PW'(rx0s * $signed(g01_q[GRAD_W-1:0]));
      p01y_q <= PW'(ry1s * $signed(g01_q[2*GRAD_W-1:GRAD_W]));
      p11x_q <= PW'(rx1s * $signed(g11_q[GRAD_W-1:0]));
      p11y_q <= PW'(ry1s * $signed(g11_q[2*GRAD_W-1:GRAD_W]));
      k5_q   <= k4_q;
      sx5_q  <= sx4_q;
      sy5_q  <= sy4_q;

      d00_q <= s00[SUMW-1:FRAC_BITS];
      d10_q <= s10[SUMW-1:FRAC_BITS];
      d01_q <= s01[SUMW-1:FRAC_BITS];
      d11_q <= s11[SUMW-1:FRAC_BITS];
      k6_q  <= k5_q;
      sx6_q <= sx5_q;
      sy6_q <= sy5_q;

      mxa_q   <= MXW'($signed({1'b0, sx6_q}) * dfa);
      mxb_q   <= MXW'($signed({1'b0, sx6_q}) * dfb);
      d00_7_q <= d00_q;
      d01_7_q <= d01_q;
      k7_q    <= k6_q;
      sy7_q   <= sy6_q;

      a8_q  <= AW'(d00_7_q) + AW'(mxa_q[MXW-1:FRAC_BITS]);
      b8_q  <= AW'(d01_7_q) + AW'(mxb_q[MXW-1:FRAC_BITS]);
      k8_q  <= k7_q;
      sy8_q <= sy7_q;

      my9_q <= MYW'($signed({1'b0, sy8_q}) * dfy);
      a9_q  <= a8_q;
      k9_q  <= k8_q;

      out_q <= sat;
    end
  end

endmodule

[design/gn_checker.sv]
module gn_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [gn_pkg::NOISE_W-1:0] m_axis_tdata_o
);
  import gn_pkg::*;

  // a waiting word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  // the pipeline stalls only behind a refused word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

  // reset empties the output
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind gradient_noise_1d_2d gn_checker u_gn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import gn_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int FLUSH_CYCLES = 40;
  localparam int N_RANDOM = 830;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  idx;
    logic [7:0]  pval;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [31:0] cx;
    logic [31:0] cy;
  } noise_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [REQ_W-1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [NOISE_W-1:0] m_axis_tdata_o;

  gradient_noise_1d_2d i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  perm_mem [TABLE_SIZE];
  logic [15:0] g1_mem [TABLE_SIZE];
  logic [31:0] g2_mem [TABLE_SIZE];

  noise_req_t pending_q[$];
  logic [15:0] noise_q[$];
  int n_errors = 0;
  int n_results = 0;
  int n_eval1 = 0;
  int n_eval2 = 0;
  int n_loads = 0;
  bit stim_done = 1'b0;
  int unsigned cycle_cnt = 0;

  function automatic longint floor_q(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic void split_coord(logic [31:0] c, output int unsigned cell_i,
                                      output longint r);
    longint t;
    t = longint'($signed(c)) + (longint'(COORD_OFFSET) <<< FRAC_BITS);
    cell_i = int'(floor_q(t)) & (TABLE_SIZE - 1);
    r = t & ((longint'(1) <<< FRAC_BITS) - 1);
  endfunction

  function automatic longint fade(longint r);
    longint r2;
    r2 = (r * r) >>> FRAC_BITS;
    return (r2 * ((longint'(3) <<< FRAC_BITS) - 2 * r)) >>> FRAC_BITS;
  endfunction

  function automatic longint blend(longint s, longint a, longint b);
    return a + floor_q(s * (b - a));
  endfunction

  function automatic int unsigned hash_at(int unsigned i);
    return perm_mem[i % TABLE_SIZE];
  endfunction

  function automatic longint grad_dot(int unsigned h, longint rx, longint ry);
    logic [31:0] g;
    g = g2_mem[h % TABLE_SIZE];
    return floor_q(rx * longint'($signed(g[15:0])) + ry * longint'($signed(g[31:16])));
  endfunction

  // returns 1 when the request yields a noise word
  function automatic bit predict_noise(noise_req_t q, output logic [15:0] nv);
    int unsigned bx0, bx1, by0, by1, hi, hj;
    longint rx0, rx1, ry0, ry1, sx, sy, u, v, a, b, res;
    nv = '0;
    case (q.kind)
      REQ_PERM: begin perm_mem[q.idx] = q.pval; return 0; end
      REQ_GRAD1: begin g1_mem[q.idx] = q.gx; return 0; end
      REQ_GRAD2: begin g2_mem[q.idx] = {q.gy, q.gx}; return 0; end
      REQ_EVAL1, REQ_EVAL2: ;
      default: return 0;
    endcase
    split_coord(q.cx, bx0, rx0);
    bx1 = (bx0 + 1) % TABLE_SIZE;
    rx1 = rx0 - (longint'(1) <<< FRAC_BITS);
    sx = fade(rx0);
    if (q.kind == REQ_EVAL1) begin
      u = floor_q(rx0 * longint'($signed(g1_mem[hash_at(bx0)])));
      v = floor_q(rx1 * longint'($signed(g1_mem[hash_at(bx1)])));
      res = blend(sx, u, v);
    end else begin
      split_coord(q.cy, by0, ry0);
      by1 = (by0 + 1) % TABLE_SIZE;
      ry1 = ry0 - (longint'(1) <<< FRAC_BITS);
      sy = fade(ry0);
      hi = hash_at(bx0);
      hj = hash_at(bx1);
      a = blend(sx, grad_dot(hash_at(hi + by0), rx0, ry0),
                grad_dot(hash_at(hj + by0), rx1, ry0));
      b = blend(sx, grad_dot(hash_at(hi + by1), rx0, ry1),
                grad_dot(hash_at(hj + by1), rx1, ry1));
      res = blend(sy, a, b);
    end
    if (res > 32767) res = 32767;
    else if (res < -32768) res = -32768;
    nv = res[15:0];
    return 1;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    n_errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  int drv_gap = 0;
  always @(posedge clk_i) begin
    noise_req_t nx;
    logic [15:0] nv;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (predict_noise(pending_q[0], nv))
          noise_q.push_back(nv);
        void'(pending_q.pop_front());
        drv_gap = pick_gap();
      end
      if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
        if (drv_gap > 0 || pending_q.size() == 0) begin
          if (drv_gap > 0) drv_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else begin
          nx = pending_q[0];
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= nx.kind;
          s_axis_tdata_i <= {nx.cy, nx.cx, nx.gy, nx.gx, nx.pval, nx.idx};
        end
      end
    end
  end

  // monitor and receiver stalls
  int rx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_results++;
        if (noise_q.size() == 0) report_mismatch("noise word with none expected");
        else begin
          logic [15:0] exp_nv;
          exp_nv = noise_q.pop_front();
          if (m_axis_tdata_o !== exp_nv)
            report_mismatch($sformatf("noise_value got %h want %h", m_axis_tdata_o, exp_nv));
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        rx_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout, %0d words pending", noise_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic noise_req_t mk_req(logic [2:0] k);
    noise_req_t q;
    q.kind = k;
    q.idx = $urandom;
    q.pval = $urandom;
    q.gx = 16'($signed($urandom_range(0, 32768)) - 16384);
    q.gy = 16'($signed($urandom_range(0, 32768)) - 16384);
    q.cx = $urandom;
    q.cy = $urandom;
    return q;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return -((COORD_OFFSET << FRAC_BITS) + $urandom_range(0, 1 << 18));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    noise_req_t q;
    int k, pick;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // fill every table entry so no evaluate reads unwritten data
    for (k = 0; k < TABLE_SIZE; k++) begin
      q = mk_req(REQ_PERM); q.idx = k; q.pval = (k * 37 + 11) & 8'hff;
      if (k == 0) q.pval = 8'hff;
      if (k == 1) q.pval = 8'h00;
      pending_q.push_back(q);
      q = mk_req(REQ_GRAD1); q.idx = k;
      if (k < 2) q.gx = k ? 16'sd16384 : -16'sd16384;
      pending_q.push_back(q);
      q = mk_req(REQ_GRAD2); q.idx = k;
      if (k < 4) begin q.gx = k[0] ? 16'h7fff : 16'h8000; q.gy = k[1] ? 16'h7fff : 16'h8000; end
      pending_q.push_back(q);
    end
    // directed: coordinate extremes, lattice points, negatives, unknown kinds
    for (k = 0; k < 20; k++) begin
      q = mk_req(k[0] ? REQ_EVAL2 : REQ_EVAL1);
      case (k / 2)
        0: begin q.cx = 32'h8000_0000; q.cy = 32'h7fff_ffff; end
        1: begin q.cx = 32'h7fff_ffff; q.cy = 32'h8000_0000; end
        2: begin q.cx = 32'h0; q.cy = 32'h0; end
        3: begin q.cx = 32'h0000_ffff; q.cy = 32'h0001_0000; end
        4: begin q.cx = -(COORD_OFFSET << FRAC_BITS); q.cy = q.cx - 1; end
        5: begin q.cx = 32'hffff_ffff; q.cy = 32'h0000_8000; end
        6: begin q.kind = 3'd5 + (k % 3); end
        default: ;
      endcase
      pending_q.push_back(q);
    end
    for (k = 0; k < N_RANDOM; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) q = mk_req(REQ_PERM);
      else if (pick < 17) q = mk_req(REQ_GRAD1);
      else if (pick < 24) q = mk_req(REQ_GRAD2);
      else if (pick < 60) q = mk_req(REQ_EVAL1);
      else if (pick < 97) q = mk_req(REQ_EVAL2);
      else q = mk_req(3'($urandom_range(5, 7)));
      if (pick < 24 && $urandom_range(0, 9) == 0) begin
        q.gx = $urandom; q.gy = $urandom;
      end
      if (pick >= 24 && $urandom_range(0, 3) == 0) begin
        q.cx = rand_coord(); q.cy = rand_coord();
      end
      pending_q.push_back(q);
    end
    wait (pending_q.size() == 0);
    wait (noise_q.size() == 0);
    repeat (FLUSH_CYCLES) @(posedge clk_i);
    $display("covered table loads, 1D and 2D evaluates and ignored kinds");
    $display("%0d noise words checked, %0d mismatches", n_results, n_errors);
    if (n_errors == 0 && noise_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/gn_pkg.sv
design/gradient_noise_1d_2d.sv
design/gn_checker.sv
bench/tb_top.sv
